// ===== rtl/core/gffrc_pkg.sv =====
// Shared codes, step tables and transfer types for the grid region capture unit.
`default_nettype none
package gffrc_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [2:0] CODE_BLANK  = 3'd0;
  localparam logic [2:0] CODE_WALL   = 3'd1;
  localparam logic [2:0] CODE_INSIDE = 3'd2;
  localparam logic [2:0] CODE_ROAD   = 3'd3;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SEED_X      = 2'd2;
  localparam logic [1:0] REG_SEED_Y      = 2'd3;

  // Neighbor step codes: stay, one up the index, one down the index.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  // Directions 0..3 are the 4-neighbors, 4..7 the diagonals.
  localparam logic [1:0] ROW_STEP [8] = '{STEP_DEC, STEP_NONE, STEP_INC, STEP_NONE,
                                          STEP_DEC, STEP_INC, STEP_INC, STEP_DEC};
  localparam logic [1:0] COL_STEP [8] = '{STEP_NONE, STEP_INC, STEP_NONE, STEP_DEC,
                                          STEP_INC, STEP_INC, STEP_DEC, STEP_DEC};

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] cell_x;
    logic [5:0] cell_y;
    logic [2:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [2:0] read_value;
    logic       done_res;
    logic       range_error;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/gffrc_engine.sv =====
// Sequencer with cell, reached and queue memories and one shared neighbor unit.
`default_nettype none
module gffrc_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int WW = $clog2(MAX_COLS + 1),
  localparam int HW = $clog2(MAX_ROWS + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 req_valid,
  output logic                req_ready,
  input  gffrc_pkg::req_t     req,
  input  wire [WW-1:0]        eff_w,
  input  wire [HW-1:0]        eff_h,
  input  wire [6:0]           seed_x,
  input  wire [5:0]           seed_y,
  output logic                resp_valid,
  input  wire                 resp_ready,
  output gffrc_pkg::res_t     resp
);
  import gffrc_pkg::*;

  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_DONE   = 4'd3;
  localparam logic [3:0] S_RCLR   = 4'd4;
  localparam logic [3:0] S_SEED   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_CUR    = 4'd7;
  localparam logic [3:0] S_NB     = 4'd8;
  localparam logic [3:0] S_NBCHK  = 4'd9;
  localparam logic [3:0] S_P2RD   = 4'd10;
  localparam logic [3:0] S_P2WR   = 4'd11;
  localparam logic [3:0] S_ERD    = 4'd12;
  localparam logic [3:0] S_ECHK   = 4'd13;
  localparam logic [3:0] S_ENB    = 4'd14;
  localparam logic [3:0] S_ENBCHK = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [AW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] pos_x_r, pos_x_nxt;
  logic [RW-1:0] pos_y_r, pos_y_nxt;
  logic [2:0]    dir_r, dir_nxt;
  res_t          res_r, res_nxt;

  // memories
  logic [2:0]    cell_mem [DEPTH];
  logic          reach_mem [DEPTH];
  logic [AW-1:0] queue_mem [DEPTH];
  logic [2:0]    cell_rd_r;
  logic          reach_rd_r;
  logic [AW-1:0] queue_rd_r;
  logic          cell_we, reach_we, queue_we;
  logic [AW-1:0] cell_wa, cell_ra, reach_wa, reach_ra, queue_ra;
  logic [2:0]    cell_wd;
  logic          reach_wd;

  // shared neighbor unit
  logic          nb_ok;
  logic [CW-1:0] nb_x;
  logic [RW-1:0] nb_y;
  logic [AW-1:0] nb_addr, pos_addr, seed_addr, req_addr;
  logic          interior, last_pos, seed_in, grid_empty, req_oob;
  logic [WW-1:0] xp1;
  logic [HW-1:0] yp1;

  always_comb begin
    xp1 = WW'(pos_x_r) + WW'(1);
    yp1 = HW'(pos_y_r) + HW'(1);
    nb_ok = 1'b1;
    nb_x = pos_x_r;
    nb_y = pos_y_r;
    case (ROW_STEP[dir_r])
      STEP_DEC: begin
        if (pos_y_r == '0) nb_ok = 1'b0;
        nb_y = pos_y_r - RW'(1);
      end
      STEP_INC: begin
        if (yp1 >= eff_h) nb_ok = 1'b0;
        nb_y = pos_y_r + RW'(1);
      end
      default: nb_y = pos_y_r;
    endcase
    case (COL_STEP[dir_r])
      STEP_DEC: begin
        if (pos_x_r == '0) nb_ok = 1'b0;
        nb_x = pos_x_r - CW'(1);
      end
      STEP_INC: begin
        if (xp1 >= eff_w) nb_ok = 1'b0;
        nb_x = pos_x_r + CW'(1);
      end
      default: nb_x = pos_x_r;
    endcase
    nb_addr    = {nb_y, nb_x};
    pos_addr   = {pos_y_r, pos_x_r};
    seed_addr  = {RW'(seed_y), CW'(seed_x)};
    req_addr   = {RW'(req.cell_y), CW'(req.cell_x)};
    interior   = (pos_x_r != '0) && (pos_y_r != '0) && (xp1 < eff_w) && (yp1 < eff_h);
    last_pos   = (xp1 >= eff_w) && (yp1 >= eff_h);
    seed_in    = (seed_x < eff_w) && (seed_y < eff_h);
    grid_empty = (eff_w == '0) || (eff_h == '0);
    req_oob    = (req.cell_x >= eff_w) || (req.cell_y >= eff_h);
  end

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    dir_nxt   = dir_r;
    res_nxt   = res_r;
    cell_we   = 1'b0;
    cell_wa   = pos_addr;
    cell_wd   = CODE_INSIDE;
    cell_ra   = pos_addr;
    reach_we  = 1'b0;
    reach_wa  = nb_addr;
    reach_wd  = 1'b1;
    reach_ra  = pos_addr;
    queue_we  = 1'b0;
    queue_ra  = head_r[AW-1:0];
    req_ready = (state_r == S_IDLE);
    resp_valid = (state_r == S_DONE);
    case (state_r)
      S_INIT: begin
        cell_we  = 1'b1;
        cell_wa  = sweep_r;
        cell_wd  = CODE_BLANK;
        reach_we = 1'b1;
        reach_wa = sweep_r;
        reach_wd = 1'b0;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          res_nxt = '0;
          case (req.mode)
            MODE_WRITE: begin
              res_nxt.done_res = 1'b1;
              res_nxt.range_error = req_oob;
              cell_we = !req_oob;
              cell_wa = req_addr;
              cell_wd = req.cell_value;
              state_nxt = S_DONE;
            end
            MODE_READ: begin
              res_nxt.done_res = 1'b1;
              res_nxt.range_error = req_oob;
              cell_ra = req_addr;
              state_nxt = req_oob ? S_DONE : S_RDWAIT;
            end
            MODE_RUN: begin
              res_nxt.done_res = 1'b1;
              sweep_nxt = '0;
              state_nxt = S_RCLR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RDWAIT: begin
        res_nxt.read_value = cell_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (resp_ready) state_nxt = S_IDLE;
      end
      S_RCLR: begin
        reach_we = 1'b1;
        reach_wa = sweep_r;
        reach_wd = 1'b0;
        sweep_nxt = sweep_r + AW'(1);
        head_nxt = '0;
        tail_nxt = '0;
        cell_ra = seed_addr;
        pos_x_nxt = '0;
        pos_y_nxt = '0;
        if (sweep_r == AW'(DEPTH - 1)) begin
          if (seed_in) state_nxt = S_SEED;
          else state_nxt = grid_empty ? S_DONE : S_P2RD;
        end
      end
      S_SEED: begin
        if (cell_rd_r == CODE_BLANK) begin
          reach_we = 1'b1;
          reach_wa = seed_addr;
          queue_we = 1'b1;
          tail_nxt = tail_r + (AW+1)'(1);
          state_nxt = S_POP;
        end else begin
          state_nxt = S_P2RD;
        end
      end
      S_POP: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + (AW+1)'(1);
          state_nxt = S_CUR;
        end else begin
          pos_x_nxt = '0;
          pos_y_nxt = '0;
          state_nxt = S_P2RD;
        end
      end
      S_CUR: begin
        pos_x_nxt = queue_rd_r[CW-1:0];
        pos_y_nxt = queue_rd_r[AW-1:CW];
        dir_nxt = '0;
        state_nxt = S_NB;
      end
      S_NB: begin
        cell_ra = nb_addr;
        reach_ra = nb_addr;
        if (nb_ok) state_nxt = S_NBCHK;
        else if (dir_r == 3'd3) state_nxt = S_POP;
        else dir_nxt = dir_r + 3'd1;
      end
      S_NBCHK: begin
        if (cell_rd_r == CODE_BLANK && !reach_rd_r) begin
          reach_we = 1'b1;
          queue_we = 1'b1;
          tail_nxt = tail_r + (AW+1)'(1);
        end
        if (dir_r == 3'd3) state_nxt = S_POP;
        else begin
          dir_nxt = dir_r + 3'd1;
          state_nxt = S_NB;
        end
      end
      S_P2RD: begin
        state_nxt = S_P2WR;
      end
      S_P2WR: begin
        if (interior && cell_rd_r == CODE_BLANK && !reach_rd_r) begin
          cell_we = 1'b1;
          cell_wd = CODE_INSIDE;
        end else if (interior && cell_rd_r == CODE_ROAD) begin
          cell_we = 1'b1;
          cell_wd = CODE_WALL;
        end
        state_nxt = S_P2RD;
        if (xp1 < eff_w) pos_x_nxt = pos_x_r + CW'(1);
        else begin
          pos_x_nxt = '0;
          pos_y_nxt = pos_y_r + RW'(1);
        end
        if (last_pos) begin
          pos_x_nxt = '0;
          pos_y_nxt = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_ECHK;
      end
      S_ECHK, S_ENB, S_ENBCHK: begin
        // decide whether this cell is finished, then step the scan
        logic finish;
        logic to_inside;
        finish = 1'b0;
        to_inside = 1'b0;
        if (state_r == S_ECHK) begin
          if (cell_rd_r == CODE_WALL) begin
            dir_nxt = '0;
            state_nxt = S_ENB;
          end else finish = 1'b1;
        end else if (state_r == S_ENB) begin
          cell_ra = nb_addr;
          if (nb_ok) state_nxt = S_ENBCHK;
          else if (dir_r == 3'd7) begin
            to_inside = 1'b1;
            finish = 1'b1;
          end else dir_nxt = dir_r + 3'd1;
        end else begin
          if (cell_rd_r == CODE_BLANK) finish = 1'b1;
          else if (dir_r == 3'd7) begin
            to_inside = 1'b1;
            finish = 1'b1;
          end else begin
            dir_nxt = dir_r + 3'd1;
            state_nxt = S_ENB;
          end
        end
        cell_we = to_inside;
        cell_wd = CODE_INSIDE;
        if (finish) begin
          state_nxt = last_pos ? S_DONE : S_ERD;
          if (xp1 < eff_w) pos_x_nxt = pos_x_r + CW'(1);
          else begin
            pos_x_nxt = '0;
            pos_y_nxt = pos_y_r + RW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign resp = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      dir_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd_r <= cell_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (reach_we) reach_mem[reach_wa] <= reach_wd;
    reach_rd_r <= reach_mem[reach_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[tail_r[AW-1:0]] <= (state_r == S_SEED) ? seed_addr : nb_addr;
    queue_rd_r <= queue_mem[queue_ra];
  end

`ifndef SYNTH
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("walk queue head passed tail");
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && req_valid && req.mode == MODE_RUN) |=> state_r == S_RCLR)
    else $error("run did not start with reached clear");
  a_enqueue_marks: assert property (@(posedge clk) disable iff (!rst_n)
    queue_we |-> (reach_we && reach_wd)) else $error("enqueue without reached mark");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= (AW+1)'(DEPTH)) else $error("walk queue overflow");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/grid_flood_fill_region_capture_unit.sv =====
// Top level: stream ports, configuration registers and result register around the engine.
// Order of work: a write goes straight to the result, a read first waits for the registered
//   cell read. A run clears the reached map, tests the seed if it lies inside the grid, floods
//   from it, then makes an interior pass and a wall pass (with a neighbor check per wall
//   cell) before the result is presented.
// Throughput: one item at a time; the cell memory's single read port and the neighbor unit set the pace.
// Reset: synchronous active-low rst_n; afterwards a clearing pass over every address zeros the
//   cell store and the reached map with in_tready low.
`default_nettype none
module grid_flood_fill_region_capture_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [15:0]  in_tdata,   // cell_x[6:0], cell_y[12:7], cell_value[15:13]
  input  wire [1:0]   in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // read_value[2:0], done_res[3], range_error[4], zero[7:5]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [7:0]   cfg_data
);
  import gffrc_pkg::*;

  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);

  logic [7:0] grid_width_r;
  logic [6:0] grid_height_r;
  logic [6:0] seed_x_r;
  logic [5:0] seed_y_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  req_t req;
  res_t resp, out_res_r;
  logic resp_valid, resp_ready, out_valid_r;

  // configuration is taken at any time; the user writes only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 8'd110;
      grid_height_r <= 7'd58;
      seed_x_r      <= 7'd75;
      seed_y_r      <= 6'd42;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data[6:0];
        REG_SEED_X:      seed_x_r      <= cfg_data[6:0];
        REG_SEED_Y:      seed_y_r      <= cfg_data[5:0];
        default:         grid_width_r  <= grid_width_r;
      endcase
    end
  end

  // saturate the grid size at the memory bounds
  assign eff_w = (32'(grid_width_r) < MAX_COLS) ? WW'(grid_width_r) : WW'(MAX_COLS);
  assign eff_h = (32'(grid_height_r) < MAX_ROWS) ? HW'(grid_height_r) : HW'(MAX_ROWS);

  assign req.mode       = in_tuser;
  assign req.cell_x     = in_tdata[6:0];
  assign req.cell_y     = in_tdata[12:7];
  assign req.cell_value = in_tdata[15:13];

  gffrc_engine #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .seed_x    (seed_x_r),
    .seed_y    (seed_y_r),
    .resp_valid(resp_valid),
    .resp_ready(resp_ready),
    .resp      (resp)
  );

  // result register: hold until the downstream transfer completes
  assign resp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) out_res_r <= resp;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.range_error, out_res_r.done_res, out_res_r.read_value};
endmodule
`default_nettype wire

// ===== tb/grid_flood_fill_region_capture_unit_tb.sv =====
// Self-checking testbench for the grid region capture unit: cell access, range checks, capture runs.
`timescale 1ns / 1ps
module grid_flood_fill_region_capture_unit_tb;
  import gffrc_pkg::*;

  localparam int COLS = 128;
  localparam int ROWS = 64;
  localparam int CELL_COUNT = COLS * ROWS;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] CODE_BACK   = 3'd4;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [15:0] in_tdata;   // cell_x[6:0], cell_y[12:7], cell_value[15:13]
  logic [1:0] in_tuser;    // mode[1:0]
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // read_value[2:0], done_res[3], range_error[4], zero[7:5]
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  grid_flood_fill_region_capture_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: cell codes and register copies.
  logic [2:0] cell_mem [CELL_COUNT];
  logic [7:0] grid_w_reg;
  logic [6:0] grid_h_reg;
  logic [6:0] seed_x_reg;
  logic [5:0] seed_y_reg;

  res_t pending_res [$];
  int   error_count;
  bit   idle_off;       // long stretch with no idling on either side
  bit   hold_go;
  int   hold_cnt;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int width_in_use();
    return (grid_w_reg < COLS) ? int'(grid_w_reg) : COLS;
  endfunction

  function automatic int height_in_use();
    return (grid_h_reg < ROWS) ? int'(grid_h_reg) : ROWS;
  endfunction

  // Flood from the seed, fill unreached interior blanks, turn interior roads to walls,
  // then promote walls with no blank around them.
  function automatic void capture_regions();
    int  w, h, cur, cx, cy, nx, ny, i;
    int  walk [$];
    bit  reached [CELL_COUNT];
    bit  blank_near;
    int  dr [8] = '{-1, 0, 1, 0, -1, 1, 1, -1};
    int  dc [8] = '{0, 1, 0, -1, 1, 1, -1, -1};
    w = width_in_use();
    h = height_in_use();
    if (seed_x_reg < w && seed_y_reg < h &&
        cell_mem[seed_y_reg * COLS + seed_x_reg] == CODE_BLANK) begin
      reached[seed_y_reg * COLS + seed_x_reg] = 1'b1;
      walk = {walk, seed_y_reg * COLS + seed_x_reg};
    end
    while (walk.size() != 0) begin
      cur = walk.pop_front();
      cy = cur / COLS;
      cx = cur % COLS;
      for (int d = 0; d < 4; d++) begin
        ny = cy + dr[d];
        nx = cx + dc[d];
        if (ny < 0 || nx < 0 || ny >= h || nx >= w) continue;
        i = ny * COLS + nx;
        if (cell_mem[i] != CODE_BLANK || reached[i]) continue;
        reached[i] = 1'b1;
        walk = {walk, i};
      end
    end
    for (int y = 1; y + 1 < h; y++)
      for (int x = 1; x + 1 < w; x++) begin
        i = y * COLS + x;
        if (cell_mem[i] == CODE_BLANK && !reached[i]) cell_mem[i] = CODE_INSIDE;
        else if (cell_mem[i] == CODE_ROAD) cell_mem[i] = CODE_WALL;
      end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        i = y * COLS + x;
        if (cell_mem[i] != CODE_WALL) continue;
        blank_near = 1'b0;
        for (int d = 0; d < 8; d++) begin
          ny = y + dr[d];
          nx = x + dc[d];
          if (ny < 0 || nx < 0 || ny >= h || nx >= w) continue;
          if (cell_mem[ny * COLS + nx] == CODE_BLANK) blank_near = 1'b1;
        end
        if (!blank_near) cell_mem[i] = CODE_INSIDE;
      end
  endfunction

  // Work out the result of one accepted item and update the predictor state.
  function automatic res_t predict_item(req_t item);
    res_t r;
    r = '0;
    if (item.mode == MODE_RUN) begin
      capture_regions();
      r.done_res = 1'b1;
    end else if (item.mode == MODE_WRITE || item.mode == MODE_READ) begin
      r.done_res = 1'b1;
      if (item.cell_x >= width_in_use() || item.cell_y >= height_in_use())
        r.range_error = 1'b1;
      else if (item.mode == MODE_WRITE)
        cell_mem[item.cell_y * COLS + item.cell_x] = item.cell_value;
      else
        r.read_value = cell_mem[item.cell_y * COLS + item.cell_x];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Drive one item at the falling edge; leave tvalid high so the next item can follow.
  task automatic send_item(logic [1:0] mode, int x, int y, int value);
    req_t item;
    res_t want_res;
    if (!idle_off && $urandom_range(0, 99) < 35) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item.mode = mode;
    item.cell_x = x[6:0];
    item.cell_y = y[5:0];
    item.cell_value = value[2:0];
    in_tdata = {item.cell_value, item.cell_y, item.cell_x};
    in_tuser = item.mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    want_res = predict_item(item);
    pending_res = {pending_res, want_res};
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, int value);
    in_tvalid = 1'b0;
    cfg_index = index;
    cfg_data = value[7:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_GRID_WIDTH:  grid_w_reg = value[7:0];
      REG_GRID_HEIGHT: grid_h_reg = value[6:0];
      REG_SEED_X:      seed_x_reg = value[6:0];
      default:         seed_y_reg = value[5:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering, let every result arrive, then settle before any register write.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_grid(int w, int h, int sx, int sy);
    drain();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_SEED_X, sx);
    write_reg(REG_SEED_Y, sy);
  endtask

  // Result checker: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result, data", out_tdata, 0);
      end else begin
        res_t want;
        want = pending_res.pop_front();
        if (out_tdata[2:0] != want.read_value)
          report_mismatch("read_value", out_tdata[2:0], want.read_value);
        if (out_tdata[3] != want.done_res)
          report_mismatch("done_res", out_tdata[3], want.done_res);
        if (out_tdata[4] != want.range_error)
          report_mismatch("range_error", out_tdata[4], want.range_error);
      end
    end
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= 400;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(negedge clk) begin
    out_tready <= (hold_cnt == 0) && (idle_off || $urandom_range(0, 99) >= 35);
  end

  task automatic test_directed_access();
    send_item(MODE_WRITE, 0, 0, 7);
    send_item(MODE_WRITE, 109, 57, 5);
    send_item(MODE_WRITE, 50, 20, 6);
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_READ, 109, 57, 0);
    send_item(MODE_READ, 50, 20, 0);
    send_item(MODE_WRITE, 110, 3, 1);   // just past the width
    send_item(MODE_READ, 3, 58, 0);     // just past the height
    send_item(MODE_READ, 127, 63, 7);
    send_item(MODE_UNUSED, 127, 63, 7); // unused mode
    send_item(MODE_UNUSED, 0, 0, 0);
  endtask

  // Small ring of walls with one side made of road, seed outside the ring.
  task automatic test_directed_capture();
    set_grid(8, 7, 0, 0);
    for (int x = 2; x <= 5; x++) begin
      send_item(MODE_WRITE, x, 1, CODE_WALL);
      send_item(MODE_WRITE, x, 5, CODE_WALL);
    end
    for (int y = 2; y <= 4; y++) begin
      send_item(MODE_WRITE, 2, y, CODE_ROAD);
      send_item(MODE_WRITE, 5, y, CODE_WALL);
    end
    send_item(MODE_WRITE, 7, 3, CODE_ROAD);  // border road stays
    send_item(MODE_WRITE, 3, 3, CODE_BACK);
    send_item(MODE_RUN, 0, 0, 0);
    for (int y = 0; y < 7; y++)
      for (int x = 0; x < 8; x++) send_item(MODE_READ, x, y, 0);
    set_grid(8, 7, 3, 3);                    // seed on a non-blank cell
    send_item(MODE_WRITE, 6, 6, CODE_BLANK);
    send_item(MODE_RUN, 0, 0, 0);
    for (int x = 0; x < 8; x++) send_item(MODE_READ, x, 6, 0);
    set_grid(8, 7, 127, 63);                 // seed outside the grid
    send_item(MODE_RUN, 0, 0, 0);
    set_grid(255, 127, 127, 63);             // saturated sizes
    send_item(MODE_WRITE, 127, 63, CODE_ROAD);
    send_item(MODE_READ, 127, 63, 0);
    send_item(MODE_RUN, 0, 0, 0);
    set_grid(0, 0, 0, 0);                    // empty grid
    send_item(MODE_WRITE, 0, 0, CODE_WALL);
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_RUN, 0, 0, 0);
  endtask

  // Receiver holds off while the sender keeps offering items, then sender waits for all results.
  task automatic test_backpressure();
    set_grid(16, 12, 1, 1);
    @(negedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    for (int k = 0; k < 30; k++)
      send_item(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 11), $urandom_range(0, 3));
    in_tvalid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    send_item(MODE_RUN, 0, 0, 0);
  endtask

  // Random phases: shapes of walls, roads and blanks on a random grid, runs and read sweeps.
  task automatic test_random_phases();
    int w, h, r, ew, eh;
    for (int p = 0; p < 8; p++) begin
      idle_off = (p == 3);
      if (p == 5)      w = 255;
      else if (p == 6) w = 3;
      else             w = $urandom_range(3, 24);
      h = (p == 5) ? 127 : (p == 6) ? 3 : $urandom_range(3, 16);
      set_grid(w, h, $urandom_range(0, (p == 2) ? 127 : w), $urandom_range(0, (p == 2) ? 63 : h));
      ew = width_in_use();
      eh = height_in_use();
      for (int k = 0; k < 105; k++) begin
        r = $urandom_range(0, 99);
        if (k == 50 || k == 104)
          send_item(MODE_RUN, $urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 7));
        else if (r < 50)
          send_item(MODE_WRITE, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(2, 7) : $urandom_range(0, 3) & 3);
        else if (r < 85)
          send_item(MODE_READ, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), 0);
        else
          send_item(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 63),
                    $urandom_range(0, 7));
      end
      if (ew * eh <= 64)
        for (int i = 0; i < ew * eh; i++) send_item(MODE_READ, i % ew, i / ew, 0);
    end
    idle_off = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_off = 1'b0;
    hold_go = 1'b0;
    hold_cnt = 0;
    error_count = 0;
    grid_w_reg = 8'd110;
    grid_h_reg = 7'd58;
    seed_x_reg = 7'd75;
    seed_y_reg = 6'd42;
    for (int i = 0; i < CELL_COUNT; i++) cell_mem[i] = CODE_BLANK;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed_access();
    test_directed_capture();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (200) @(negedge clk);
    if (error_count == 0 && pending_res.size() == 0) begin
      $display("grid_flood_fill_region_capture_unit_tb: clean");
    end else begin
      $display("grid_flood_fill_region_capture_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #80_000_000;
    $display("grid_flood_fill_region_capture_unit_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gffrc_pkg.sv
rtl/core/gffrc_engine.sv
rtl/core/grid_flood_fill_region_capture_unit.sv
tb/grid_flood_fill_region_capture_unit_tb.sv
